>>> sv/ppu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared constants, slot record type and saturation helper for the particle pool core
// no dependencies

package ppu_pkg;

    localparam int POOL_SIZE = 64;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int CNT_W     = $clog2(POOL_SIZE + 1);
    localparam int DIV_STEPS = 17;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [16:0] HALF_Q16 = 17'd32768;
    localparam logic [16:0] RATIO_MAX = 17'd65536;

    localparam int IN_W   = 272;
    localparam int OUT_W  = 144;
    localparam int CFG_IW = 3;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_COLOR_BEGIN = 3'd0;
    localparam logic [CFG_IW-1:0] REG_COLOR_END   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_SIZE_BEGIN  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_SIZE_END    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_SIZE_VAR    = 3'd4;
    localparam logic [CFG_IW-1:0] REG_LIFETIME    = 3'd5;
    localparam logic [CFG_IW-1:0] REG_GRAVITY     = 3'd6;
    localparam logic [CFG_IW-1:0] REG_MODE        = 3'd7;

    localparam logic OP_EMIT = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [15:0]        bsize;
        logic [23:0]        life_left;
        logic signed [31:0] rot;
        logic               spins;
        logic [31:0]        cbeg;
        logic [31:0]        cend;
        logic [15:0]        send;
        logic [15:0]        life;
        logic signed [31:0] grav;
    } slot_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -50'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/particle_pool_update_core.sv
`timescale 1ns / 1ps
`default_nettype none
// particle pool core: emit and tick items, slot memory, euler update, quad output
// depends on ppu_pkg
//
// usage:
//  - s_ channel takes items; s_tuser is op (0 emit, 1 tick), s_tdata the payload
//  - m_ channel returns quads for a tick, m_tlast on the final one of each tick;
//    m_tuser is quad_valid, 0 only on the single empty item of a tick with no live particle
//  - cfg_ channel writes the eight registers, always ready, write only while idle
//  - an emit passes through ST_EM1 and ST_EM2 and produces no output
//  - a tick walks all 64 slots in pool order: an empty slot is skipped in ST_NEXT,
//    a retired slot passes ST_NEXT and ST_RD, a live slot passes ST_NEXT, ST_RD,
//    ST_SUM, the ratio divider in ST_DIV, ST_LMUL and ST_QUAD; the tick closes in ST_FIN
//  - one item at a time; s_tready is high only while the core waits for an item
//  - each quad is held back one step so that m_tlast can be set on the final one;
//    a stalled receiver stalls the walk, nothing is dropped
//  - synchronous active-low reset clears all live flags and returns the registers and the
//    pointer to their reset values; slot memory itself is not cleared

module particle_pool_update_core (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // pos_x, pos_y, vel_x, vel_y, vel_var_x, vel_var_y, rand_vx, rand_vy,
    // rand_size, rand_rot, tick_dt, zero pad
    input  wire logic [ppu_pkg::IN_W-1:0]  s_tdata,
    // op
    input  wire logic [0:0]                s_tuser,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // quad_x, quad_y, quad_size, quad_rotation, quad_color
    output logic [ppu_pkg::OUT_W-1:0]      m_tdata,
    // quad_valid
    output logic [0:0]                     m_tuser,
    output logic                           m_tlast,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [ppu_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [31:0]               cfg_data
);
    import ppu_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EM1, ST_EM2, ST_NEXT, ST_RD, ST_SUM, ST_DIV, ST_LMUL, ST_QUAD, ST_FIN
    } state_t;

    state_t state_reg;

    // configuration
    logic [31:0]        color_begin_reg, color_end_reg;
    logic [15:0]        size_begin_reg, size_end_reg, size_var_reg, lifetime_reg;
    logic signed [31:0] gravity_reg;
    logic [1:0]         mode_reg;

    // input item
    logic signed [31:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic [30:0]        vvx_reg, vvy_reg;
    logic [15:0]        rvx_reg, rvy_reg, rsize_reg, rrot_reg, dt_reg;

    // pool
    slot_t              mem [POOL_SIZE];
    slot_t              rd_reg;
    slot_t              upd_reg;
    logic [POOL_SIZE-1:0] alive_reg;
    logic [IDX_W-1:0]   ptr_reg, idx_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // arithmetic
    logic signed [48:0] pa_reg, pb_reg, pc_reg;
    logic signed [33:0] ps_reg;
    logic [47:0]        prot_reg;
    logic [23:0]        life_new_reg;
    logic [16:0]        rem_reg, quo_reg, nbits_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic signed [34:0] lsz_reg;
    logic signed [26:0] lcol_reg [4];

    // output
    logic               m_valid_reg, m_last_reg, m_quad_reg;
    logic [OUT_W-1:0]   m_data_reg;
    logic               pend_valid_reg;
    logic [OUT_W-1:0]   pend_reg;

    logic               out_free;
    logic               out_load;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    slot_t              mem_wd;
    slot_t              emit_slot;
    slot_t              tick_slot;
    logic [OUT_W-1:0]   quad_data;
    logic [17:0]        div_t;
    logic [16:0]        div_den;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
        if (v == IDX_W'(POOL_SIZE - 1)) begin
            return '0;
        end
        return v + 1'b1;
    endfunction

    function automatic logic signed [16:0] centered(input logic [15:0] r);
        return $signed({1'b0, r}) - $signed(HALF_Q16);
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_quad_reg;
    assign m_tlast   = m_last_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign out_load  = out_free && (state_reg == ST_QUAD || state_reg == ST_FIN);

    // emit record
    always_comb begin
        logic signed [49:0] sx, sy;
        logic signed [17:0] sz;
        emit_slot = '0;
        sx = 50'(vel_x_reg) + 50'(pa_reg >>> 16);
        sy = 50'(vel_y_reg) + 50'(pb_reg >>> 16);
        sz = $signed({2'b0, size_begin_reg}) + 18'(ps_reg >>> 16);
        emit_slot.pos_x = pos_x_reg;
        emit_slot.pos_y = pos_y_reg;
        emit_slot.vel_x = sat32(sx);
        emit_slot.vel_y = sat32(sy);
        if (sz < 0) begin
            emit_slot.bsize = '0;
        end else if (sz > 18'sd65535) begin
            emit_slot.bsize = 16'hffff;
        end else begin
            emit_slot.bsize = sz[15:0];
        end
        emit_slot.life_left = {lifetime_reg, 8'b0};
        emit_slot.spins     = !mode_reg[0] && mode_reg[1];
        emit_slot.rot       = emit_slot.spins ? 32'(centered(rrot_reg) * 17'sd45) : '0;
        emit_slot.cbeg      = color_begin_reg;
        emit_slot.cend      = color_end_reg;
        emit_slot.send      = size_end_reg;
        emit_slot.life      = lifetime_reg;
        emit_slot.grav      = gravity_reg;
    end

    // tick update
    always_comb begin
        tick_slot = rd_reg;
        tick_slot.life_left = life_new_reg;
        tick_slot.pos_x = sat32(50'(rd_reg.pos_x) + 50'(pa_reg >>> 16));
        tick_slot.pos_y = sat32(50'(rd_reg.pos_y) + 50'(pb_reg >>> 16));
        tick_slot.vel_y = sat32(50'(rd_reg.vel_y) - 50'(pc_reg >>> 16));
        if (rd_reg.spins) begin
            tick_slot.rot = sat32(50'(rd_reg.rot) + 50'({1'b0, prot_reg[47:30]}));
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = ptr_reg;
        mem_wd = emit_slot;
        if (state_reg == ST_EM2) begin
            mem_we = 1'b1;
        end else if (state_reg == ST_SUM) begin
            mem_we = 1'b1;
            mem_wa = idx_reg;
            mem_wd = tick_slot;
        end
    end

    // divider step
    assign div_den = {1'b0, upd_reg.life};
    assign div_t   = {1'b0, rem_reg[15:0], nbits_reg[16]};

    // quad assembly from lerp products
    always_comb begin
        logic [15:0] sz;
        logic [31:0] col;
        logic [31:0] rot;
        sz  = 16'(upd_reg.send + 16'(lsz_reg >>> 16));
        col = '0;
        for (int c = 0; c < 4; c++) begin
            col[8*c +: 8] = 8'(upd_reg.cend[8*c +: 8] + 8'(lcol_reg[c] >>> 16));
        end
        rot = upd_reg.spins ? upd_reg.rot : '0;
        quad_data = {col, rot, sz, upd_reg.pos_y, upd_reg.pos_x};
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_reg <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            color_begin_reg <= 32'hffffffff;
            color_end_reg   <= '0;
            size_begin_reg  <= 16'd256;
            size_end_reg    <= '0;
            size_var_reg    <= '0;
            lifetime_reg    <= 16'd256;
            gravity_reg     <= '0;
            mode_reg        <= '0;
            alive_reg       <= '0;
            ptr_reg         <= IDX_W'(POOL_SIZE - 1);
            idx_reg         <= '0;
            cnt_reg         <= '0;
            dcnt_reg        <= '0;
            m_valid_reg     <= 1'b0;
            m_last_reg      <= 1'b0;
            m_quad_reg      <= 1'b0;
            pend_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    REG_COLOR_BEGIN: color_begin_reg <= cfg_data;
                    REG_COLOR_END:   color_end_reg   <= cfg_data;
                    REG_SIZE_BEGIN:  size_begin_reg  <= cfg_data[15:0];
                    REG_SIZE_END:    size_end_reg    <= cfg_data[15:0];
                    REG_SIZE_VAR:    size_var_reg    <= cfg_data[15:0];
                    REG_LIFETIME:    lifetime_reg    <= cfg_data[15:0];
                    REG_GRAVITY:     gravity_reg     <= cfg_data;
                    REG_MODE:        mode_reg        <= cfg_data[1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        pos_x_reg <= s_tdata[31:0];
                        pos_y_reg <= s_tdata[63:32];
                        vel_x_reg <= s_tdata[95:64];
                        vel_y_reg <= s_tdata[127:96];
                        vvx_reg   <= s_tdata[158:128];
                        vvy_reg   <= s_tdata[189:159];
                        rvx_reg   <= s_tdata[205:190];
                        rvy_reg   <= s_tdata[221:206];
                        rsize_reg <= s_tdata[237:222];
                        rrot_reg  <= s_tdata[253:238];
                        dt_reg    <= s_tdata[269:254];
                        if (s_tuser[0] == OP_EMIT) begin
                            state_reg <= ST_EM1;
                        end else begin
                            idx_reg   <= mode_reg[0] ? wrap_inc(ptr_reg) : '0;
                            cnt_reg   <= '0;
                            state_reg <= ST_NEXT;
                        end
                    end
                end
                ST_EM1: begin
                    pa_reg    <= $signed({1'b0, vvx_reg}) * centered(rvx_reg);
                    pb_reg    <= $signed({1'b0, vvy_reg}) * centered(rvy_reg);
                    ps_reg    <= $signed({1'b0, size_var_reg}) * centered(rsize_reg);
                    state_reg <= ST_EM2;
                end
                ST_EM2: begin
                    alive_reg[ptr_reg] <= 1'b1;
                    if (!mode_reg[0]) begin
                        ptr_reg <= (ptr_reg == '0) ? IDX_W'(POOL_SIZE - 1) : ptr_reg - 1'b1;
                    end else begin
                        ptr_reg <= wrap_inc(ptr_reg);
                    end
                    state_reg <= ST_IDLE;
                end
                ST_NEXT: begin
                    if (cnt_reg == CNT_W'(POOL_SIZE)) begin
                        state_reg <= ST_FIN;
                    end else if (!alive_reg[idx_reg]) begin
                        idx_reg <= wrap_inc(idx_reg);
                        cnt_reg <= cnt_reg + 1'b1;
                    end else begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    if (rd_reg.life_left == '0) begin
                        alive_reg[idx_reg] <= 1'b0;
                        idx_reg   <= wrap_inc(idx_reg);
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= ST_NEXT;
                    end else begin
                        pa_reg   <= rd_reg.vel_x * $signed({1'b0, dt_reg});
                        pb_reg   <= rd_reg.vel_y * $signed({1'b0, dt_reg});
                        pc_reg   <= rd_reg.grav * $signed({1'b0, dt_reg});
                        prot_reg <= PI_Q30 * dt_reg;
                        life_new_reg <= (rd_reg.life_left > 24'(dt_reg)) ?
                                        rd_reg.life_left - 24'(dt_reg) : '0;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    upd_reg   <= tick_slot;
                    rem_reg   <= {2'b0, life_new_reg[23:9]};
                    nbits_reg <= {life_new_reg[8:0], 8'b0};
                    quo_reg   <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_t >= {1'b0, div_den}) begin
                        rem_reg <= 17'(div_t - {1'b0, div_den});
                        quo_reg <= {quo_reg[15:0], 1'b1};
                    end else begin
                        rem_reg <= div_t[16:0];
                        quo_reg <= {quo_reg[15:0], 1'b0};
                    end
                    nbits_reg <= {nbits_reg[15:0], 1'b0};
                    dcnt_reg  <= dcnt_reg + 1'b1;
                    if (dcnt_reg == DCNT_W'(DIV_STEPS - 1)) begin
                        state_reg <= ST_LMUL;
                    end
                end
                ST_LMUL: begin
                    logic [16:0] ratio;
                    ratio = (quo_reg > RATIO_MAX) ? RATIO_MAX : quo_reg;
                    lsz_reg <= ($signed({1'b0, upd_reg.bsize}) - $signed({1'b0, upd_reg.send}))
                               * $signed({1'b0, ratio});
                    for (int c = 0; c < 4; c++) begin
                        lcol_reg[c] <= ($signed({1'b0, upd_reg.cbeg[8*c +: 8]})
                                       - $signed({1'b0, upd_reg.cend[8*c +: 8]}))
                                       * $signed({1'b0, ratio});
                    end
                    state_reg <= ST_QUAD;
                end
                ST_QUAD: begin
                    if (out_free) begin
                        // push the held quad, hold this one until the next is known
                        m_valid_reg    <= pend_valid_reg;
                        m_data_reg     <= pend_reg;
                        m_quad_reg     <= 1'b1;
                        m_last_reg     <= 1'b0;
                        pend_reg       <= quad_data;
                        pend_valid_reg <= 1'b1;
                        idx_reg        <= wrap_inc(idx_reg);
                        cnt_reg        <= cnt_reg + 1'b1;
                        state_reg      <= ST_NEXT;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_data_reg     <= pend_valid_reg ? pend_reg : '0;
                        m_quad_reg     <= pend_valid_reg;
                        m_last_reg     <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("held quad left over while idle");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata == '0))
        else $error("empty tick item not last or not zero");

    a_fin_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free) |=> (state_reg == ST_IDLE && m_tvalid && m_tlast))
        else $error("tick did not close with a last item");

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (dcnt_reg < DCNT_W'(DIV_STEPS)))
        else $error("divider step count overrun");

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// self-checking bench for particle_pool_update_core: emits and ticks with random pacing,
// every quad checked against an in-bench model of the particle pool
// depends on ppu_pkg and particle_pool_update_core

module tb;
    import ppu_pkg::*;

    localparam int STALL_LIMIT = 5000;

    typedef struct {
        bit          op;
        bit [31:0]   px, py, vx, vy;
        bit [30:0]   varx, vary;
        bit [15:0]   rvx, rvy, rsz, rrot, dt;
    } item_t;

    typedef struct {
        bit        qv;
        bit [31:0] x, y;
        bit [15:0] sz;
        bit [31:0] rot, color;
        bit        last;
    } quad_t;

    typedef struct {
        bit          alive;
        longint      px, py, vx, vy, rot, grav;
        int unsigned bsz, life_left;
        bit          spins;
        bit [31:0]   cb, ce;
        bit [15:0]   se, life;
    } particle_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    particle_pool_update_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // model state
    particle_t pool [POOL_SIZE];
    bit [31:0] reg_val [8];
    int unsigned slot_ptr;
    quad_t quads_due [$];

    int mismatches = 0;
    int errors = 0;
    int n_emits = 0;
    int n_ticks = 0;
    int n_quads = 0;
    int max_gap = 12;
    int idle_cycles = 0;

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint centered(bit [15:0] r);
        return longint'(r) - 32768;
    endfunction

    function automatic longint blend(longint endv, longint begv, longint ratio);
        return endv + (((begv - endv) * ratio) >>> 16);
    endfunction

    function automatic bit [IN_W-1:0] pack_item(item_t it);
        return {2'b0, it.dt, it.rrot, it.rsz, it.rvy, it.rvx, it.vary, it.varx,
                it.vy, it.vx, it.py, it.px};
    endfunction

    task automatic apply_emit(item_t it);
        int unsigned p;
        longint sz;
        p = slot_ptr;
        pool[p].alive = 1'b1;
        pool[p].px = longint'(signed'(it.px));
        pool[p].py = longint'(signed'(it.py));
        pool[p].vx = clip32(longint'(signed'(it.vx)) +
                            ((longint'(it.varx) * centered(it.rvx)) >>> 16));
        pool[p].vy = clip32(longint'(signed'(it.vy)) +
                            ((longint'(it.vary) * centered(it.rvy)) >>> 16));
        sz = longint'(reg_val[REG_SIZE_BEGIN][15:0]) +
             ((longint'(reg_val[REG_SIZE_VAR][15:0]) * centered(it.rsz)) >>> 16);
        if (sz < 0) sz = 0;
        if (sz > 65535) sz = 65535;
        pool[p].bsz = int'(sz);
        pool[p].life = reg_val[REG_LIFETIME][15:0];
        pool[p].life_left = int'(reg_val[REG_LIFETIME][15:0]) << 8;
        pool[p].cb = reg_val[REG_COLOR_BEGIN];
        pool[p].ce = reg_val[REG_COLOR_END];
        pool[p].se = reg_val[REG_SIZE_END][15:0];
        pool[p].grav = longint'(signed'(reg_val[REG_GRAVITY]));
        pool[p].spins = !reg_val[REG_MODE][0] && reg_val[REG_MODE][1];
        pool[p].rot = pool[p].spins ? centered(it.rrot) * 45 : 0;
        if (!reg_val[REG_MODE][0]) slot_ptr = (p == 0) ? POOL_SIZE - 1 : p - 1;
        else slot_ptr = (p + 1) % POOL_SIZE;
    endtask

    task automatic apply_tick(bit [15:0] dt);
        int unsigned idx;
        longint ratio;
        longint sdt;
        quad_t q;
        int produced;
        produced = 0;
        sdt = longint'(dt);
        idx = reg_val[REG_MODE][0] ? (slot_ptr + 1) % POOL_SIZE : 0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (pool[idx].alive) begin
                if (pool[idx].life_left == 0) begin
                    pool[idx].alive = 1'b0;
                end else begin
                    pool[idx].life_left = (pool[idx].life_left > dt) ?
                                          pool[idx].life_left - dt : 0;
                    pool[idx].px = clip32(pool[idx].px + ((pool[idx].vx * sdt) >>> 16));
                    pool[idx].py = clip32(pool[idx].py + ((pool[idx].vy * sdt) >>> 16));
                    pool[idx].vy = clip32(pool[idx].vy - ((pool[idx].grav * sdt) >>> 16));
                    if (pool[idx].spins)
                        pool[idx].rot = clip32(pool[idx].rot +
                                               ((longint'(PI_Q30) * sdt) >>> 30));
                    if (pool[idx].life == 0) begin
                        ratio = 0;
                    end else begin
                        ratio = (longint'(pool[idx].life_left) << 8) / pool[idx].life;
                        if (ratio > 65536) ratio = 65536;
                    end
                    q.qv = 1'b1;
                    q.x = pool[idx].px[31:0];
                    q.y = pool[idx].py[31:0];
                    q.sz = 16'(blend(pool[idx].se, pool[idx].bsz, ratio));
                    q.rot = pool[idx].spins ? pool[idx].rot[31:0] : 32'd0;
                    for (int c = 0; c < 4; c++)
                        q.color[8*c +: 8] = 8'(blend(pool[idx].ce[8*c +: 8],
                                                     pool[idx].cb[8*c +: 8], ratio));
                    q.last = 1'b0;
                    quads_due.push_back(q);
                    produced++;
                end
            end
            idx = (idx + 1) % POOL_SIZE;
        end
        if (produced == 0) begin
            q = '{default: 0};
            quads_due.push_back(q);
        end
        quads_due[$].last = 1'b1;
    endtask

    // one item on the s_ channel; valid stays up when the next item follows at once
    task automatic send_item(item_t it);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= pack_item(it);
        do @(posedge aclk); while (!s_tready);
        if (it.op == OP_EMIT) begin
            apply_emit(it);
            n_emits++;
        end else begin
            apply_tick(it.dt);
            n_ticks++;
        end
    endtask

    task automatic finish_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic settle();
        finish_sending();
        wait (quads_due.size() == 0);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, bit [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODE:                                   reg_val[idx] = {30'd0, val[1:0]};
            REG_SIZE_BEGIN, REG_SIZE_END, REG_SIZE_VAR,
            REG_LIFETIME:                               reg_val[idx] = {16'd0, val[15:0]};
            default:                                    reg_val[idx] = val;
        endcase
    endtask

    function automatic item_t rand_item(bit op);
        item_t it;
        it.op = op;
        it.px = $urandom; it.py = $urandom; it.vx = $urandom; it.vy = $urandom;
        it.varx = 31'($urandom); it.vary = 31'($urandom);
        it.rvx = 16'($urandom); it.rvy = 16'($urandom);
        it.rsz = 16'($urandom); it.rrot = 16'($urandom);
        it.dt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
        if ($urandom_range(0, 2) == 0) begin
            // moderate motion so positions do not pin at the rails
            it.vx = 32'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
            it.vy = 32'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
            it.varx = 31'($urandom_range(0, 1 << 18));
            it.vary = 31'($urandom_range(0, 1 << 18));
        end
        return it;
    endfunction

    // result side: random stall per item, checks each quad in order
    int m_wait = 0;
    always @(posedge aclk) begin
        quad_t got;
        quad_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.qv = m_tuser[0];
                got.x = m_tdata[31:0];
                got.y = m_tdata[63:32];
                got.sz = m_tdata[79:64];
                got.rot = m_tdata[111:80];
                got.color = m_tdata[143:112];
                got.last = m_tlast;
                n_quads++;
                if (quads_due.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected quad %p", got);
                end else begin
                    want = quads_due.pop_front();
                    if (got != want) begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("quad mismatch: expected %p got %p", want, got);
                    end
                end
                m_wait = $urandom_range(0, max_gap);
                m_tready <= (m_wait == 0);
            end else if (!m_tready) begin
                if (m_wait > 0) m_wait--;
                if (m_wait == 0) m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("** particle_pool_update_core: FAILED **");
            $finish;
        end
    end

    task automatic test_directed();
        item_t it;
        // empty pool tick
        it = rand_item(OP_TICK);
        send_item(it);
        settle();
        // field extremes with size clamps low then high
        write_reg(REG_SIZE_BEGIN, 32'd0);
        write_reg(REG_SIZE_VAR, 32'hFFFF);
        it = '{op: OP_EMIT, px: 32'h7FFFFFFF, py: 32'h80000000, vx: 32'h7FFFFFFF,
               vy: 32'h80000000, varx: 31'h7FFFFFFF, vary: 31'h7FFFFFFF,
               rvx: 16'hFFFF, rvy: 16'h0000, rsz: 16'h0000, rrot: 16'h0000, dt: 16'h0};
        send_item(it);
        it = '{op: OP_EMIT, px: 32'h0, py: 32'hFFFFFFFF, vx: 32'h80000000,
               vy: 32'h7FFFFFFF, varx: 31'h0, vary: 31'h0,
               rvx: 16'h8000, rvy: 16'hFFFF, rsz: 16'hFFFF, rrot: 16'hFFFF, dt: 16'hFFFF};
        send_item(it);
        it.op = OP_TICK; it.dt = 16'h0;
        send_item(it);
        it.dt = 16'hFFFF;
        send_item(it);
        settle();
        write_reg(REG_SIZE_BEGIN, 32'hFFFF);
        write_reg(REG_MODE, 32'd2);
        write_reg(REG_GRAVITY, 32'h80000000);
        write_reg(REG_LIFETIME, 32'd1);
        it = rand_item(OP_EMIT); it.rsz = 16'hFFFF; it.rrot = 16'h0;
        send_item(it);
        it = rand_item(OP_EMIT); it.rrot = 16'hFFFF;
        send_item(it);
        // life runs out, quad with ratio 0, then retired on the next tick
        for (int k = 0; k < 3; k++) begin
            it = rand_item(OP_TICK); it.dt = 16'd200;
            send_item(it);
        end
        settle();
        write_reg(REG_MODE, 32'd3);
        write_reg(REG_GRAVITY, 32'h7FFFFFFF);
        write_reg(REG_LIFETIME, 32'hFFFF);
        for (int k = 0; k < 4; k++) send_item(rand_item(OP_EMIT));
        for (int k = 0; k < 3; k++) send_item(rand_item(OP_TICK));
        settle();
    endtask

    task automatic test_random_phases();
        int n_phase;
        item_t it;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_COLOR_BEGIN, (ph == 0) ? 32'h0 : $urandom);
            write_reg(REG_COLOR_END, (ph == 1) ? 32'hFFFFFFFF : $urandom);
            write_reg(REG_SIZE_BEGIN, 32'($urandom_range(0, 65535)));
            write_reg(REG_SIZE_END, (ph == 2) ? 32'hFFFF : 32'($urandom_range(0, 65535)));
            write_reg(REG_SIZE_VAR, 32'($urandom_range(0, 65535)));
            write_reg(REG_LIFETIME, (ph == 3) ? 32'hFFFF : 32'($urandom_range(1, 12)));
            write_reg(REG_GRAVITY, $urandom);
            write_reg(REG_MODE, 32'(ph % 4));
            max_gap = (ph % 3 == 2) ? 0 : 12;
            n_phase = 52;
            for (int k = 0; k < n_phase; k++) begin
                it = rand_item(($urandom_range(0, 99) < 40) ? OP_TICK : OP_EMIT);
                send_item(it);
            end
            settle();
        end
        max_gap = 12;
    endtask

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) pool[i] = '{default: 0};
        reg_val[REG_COLOR_BEGIN] = 32'hFFFFFFFF;
        reg_val[REG_COLOR_END] = 32'd0;
        reg_val[REG_SIZE_BEGIN] = 32'd256;
        reg_val[REG_SIZE_END] = 32'd0;
        reg_val[REG_SIZE_VAR] = 32'd0;
        reg_val[REG_LIFETIME] = 32'd256;
        reg_val[REG_GRAVITY] = 32'd0;
        reg_val[REG_MODE] = 32'd0;
        slot_ptr = POOL_SIZE - 1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        m_tready <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_phases();

        settle();
        repeat (100) @(posedge aclk);
        $display("covered %0d emits and %0d ticks, %0d quads checked, all modes and",
                 n_emits, n_ticks, n_quads);
        $display("register extremes, with and without idle cycles on both channels");
        if (errors == 0 && quads_due.size() == 0) begin
            $display("** particle_pool_update_core: PASSED **");
        end else begin
            $display("%0d errors, %0d quads still due", errors, quads_due.size());
            $display("** particle_pool_update_core: FAILED **");
        end
        $finish;
    end

endmodule
